>>> src/rlx_pkg.sv
// Shared types, constants and decode helpers for the rotate-left-through-extend unit.
`default_nettype none
package rlx_pkg;

	// Operand size field of the instruction word
	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_WORD = 2'd1,
		SZ_LONG = 2'd2,
		SZ_MEM  = 2'd3
	} size_t;

	// Ring widths: operand bits plus the extend bit
	localparam logic [5:0] RING_BYTE = 6'd9;
	localparam logic [5:0] RING_WORD = 6'd17;
	localparam logic [5:0] RING_LONG = 6'd33;

	// Cycle accounting
	localparam logic [7:0] CYC_BASE       = 8'd6;
	localparam logic [7:0] CYC_LONG_EXTRA = 8'd2;
	localparam logic [7:0] CYC_MEM        = 8'd8;

	// Immediate count of zero stands for eight
	localparam logic [5:0] IMM_ZERO_COUNT = 6'd8;

	// Default depth of the decode-to-execute queue
	localparam int QUEUE_DEPTH_DEF = 2;

	// Decoded instruction handed from front to back
	typedef struct packed {
		size_t       sz;
		logic [5:0]  rot;     // count reduced modulo the ring width
		logic        x;
		logic [31:0] operand;
		logic [7:0]  cycles;
	} entry_t;

	// Count reduced modulo the ring width; count < 64 < 8 * width since width >= 9,
	// so three binary compare-subtract steps (4w, 2w, w) on eight-bit values suffice
	function automatic logic [5:0] ring_mod(input logic [5:0] cnt, input logic [5:0] w);
		logic [7:0] r;
		logic [7:0] ww;
		r  = {2'b00, cnt};
		ww = {2'b00, w};
		for (int i = 2; i >= 0; i--) begin
			if (r >= (ww << i)) begin
				r = r - (ww << i);
			end
		end
		return r[5:0];
	endfunction

endpackage
`default_nettype wire

>>> src/rotate_left_through_extend.sv
// Top level of the rotate-left-through-extend execution unit.
// Each input transaction carries one ROXL instruction (opcode, destination operand, count
// register bits, X flag) and yields exactly one result transaction holding the merged value,
// the X/C/N/Z/V flags and the instruction cycle count. The front end decodes each
// transaction combinationally into a queue of QUEUE_DEPTH entries; the back end performs
// doubled-ring barrel rotates, one per size, and loads the output register. Sustained rate
// is one transaction per clock while the master side does not stall; each result passes
// through the queue and output register, which absorb up to QUEUE_DEPTH + 1 items while
// the master side stalls. No clearing pass or warm-up is needed after reset.
`default_nettype none
module rotate_left_through_extend #(
	parameter int QUEUE_DEPTH = rlx_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // opcode[15:0], operand[47:16], count_reg[53:48],
	                                    // x_in[54], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // result[31:0], x_out[32], c_out[33], n_out[34],
	                                    // z_out[35], v_out[36], cycles[44:37], zero pad
);

	logic            push_valid;
	logic            push_ready;
	rlx_pkg::entry_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	rlx_pkg::entry_t pop_data;

	rlx_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	rlx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rlx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pop_valid),
		.in_ready (pop_ready),
		.in_data  (pop_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

>>> src/rlx_front.sv
// Front end: accepts instruction transactions and decodes size, count and cycles.
`default_nettype none
module rlx_front (
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [55:0]    s_tdata,   // opcode[15:0], operand[47:16], count_reg[53:48], x_in[54]
	output logic                push_valid,
	input  wire logic           push_ready,
	output rlx_pkg::entry_t     push_data
);

	logic [15:0]      opcode;
	logic [31:0]      operand;
	logic [5:0]       count_reg;
	logic             x_in;
	rlx_pkg::size_t   sz;
	logic [5:0]       count;
	logic [5:0]       width;
	logic [7:0]       cyc;

	assign opcode    = s_tdata[15:0];
	assign operand   = s_tdata[47:16];
	assign count_reg = s_tdata[53:48];
	assign x_in      = s_tdata[54];
	assign sz        = rlx_pkg::size_t'(opcode[7:6]);

	// Count selection and ring width per form
	always_comb begin
		count = 6'd1;
		width = rlx_pkg::RING_WORD;
		cyc   = rlx_pkg::CYC_MEM;
		if (sz != rlx_pkg::SZ_MEM) begin
			if (opcode[5]) begin
				count = count_reg;
			end else if (opcode[11:9] == 3'd0) begin
				count = rlx_pkg::IMM_ZERO_COUNT;
			end else begin
				count = {3'd0, opcode[11:9]};
			end
			cyc = rlx_pkg::CYC_BASE + {1'b0, count, 1'b0};
			case (sz)
				rlx_pkg::SZ_BYTE: width = rlx_pkg::RING_BYTE;
				rlx_pkg::SZ_WORD: width = rlx_pkg::RING_WORD;
				rlx_pkg::SZ_LONG: begin
					width = rlx_pkg::RING_LONG;
					cyc   = cyc + rlx_pkg::CYC_LONG_EXTRA;
				end
				default: width = rlx_pkg::RING_WORD;
			endcase
		end
	end

	// Hand decoded item to the queue
	assign push_valid        = s_tvalid;
	assign s_tready          = push_ready;
	assign push_data.sz      = sz;
	assign push_data.rot     = rlx_pkg::ring_mod(count, width);
	assign push_data.x       = x_in;
	assign push_data.operand = operand;
	assign push_data.cycles  = cyc;

endmodule
`default_nettype wire

>>> src/rlx_queue.sv
// Short FIFO that decouples the decode front from the execute back.
`default_nettype none
module rlx_queue #(
	parameter int DEPTH = rlx_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire rlx_pkg::entry_t push_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output rlx_pkg::entry_t      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rlx_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            push;
	logic            pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Fill count bounds and bookkeeping
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue fill count exceeds depth");

	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
		else $error("queue count did not grow on push");

	a_cnt_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == CW'($past(cnt_q) - 1'b1)))
		else $error("queue count did not shrink on pop");

	a_ptr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with unequal pointers");

endmodule
`default_nettype wire

>>> src/rlx_back.sv
// Execute back end: ring rotation, flag generation and the output register.
`default_nettype none
module rlx_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire rlx_pkg::entry_t in_data,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [47:0]          m_tdata   // result[31:0], x_out[32], c_out[33], n_out[34],
	                                       // z_out[35], v_out[36], cycles[44:37], zero pad
);

	logic [17:0] sh_b;
	logic [33:0] sh_w;
	logic [65:0] sh_l;
	logic [8:0]  rot_b;
	logic [16:0] rot_w;
	logic [32:0] rot_l;
	logic [31:0] res;
	logic        xo;
	logic        n;
	logic        z;
	logic [31:0] res_q;
	logic        xo_q;
	logic        n_q;
	logic        z_q;
	logic [7:0]  cyc_q;
	logic        valid_q;
	logic        take;

	// Doubled-ring barrel rotates, one per size
	assign sh_b  = {in_data.x, in_data.operand[7:0], in_data.x, in_data.operand[7:0]}
		<< in_data.rot;
	assign sh_w  = {in_data.x, in_data.operand[15:0], in_data.x, in_data.operand[15:0]}
		<< in_data.rot;
	assign sh_l  = {in_data.x, in_data.operand, in_data.x, in_data.operand} << in_data.rot;
	assign rot_b = sh_b[17:9];
	assign rot_w = sh_w[33:17];
	assign rot_l = sh_l[65:33];

	// Merge with kept upper bits (cleared for the memory form) and derive flags
	always_comb begin
		case (in_data.sz)
			rlx_pkg::SZ_BYTE: begin
				res = {in_data.operand[31:8], rot_b[7:0]};
				xo  = rot_b[8];
				n   = rot_b[7];
				z   = (rot_b[7:0] == 8'd0);
			end
			rlx_pkg::SZ_WORD: begin
				res = {in_data.operand[31:16], rot_w[15:0]};
				xo  = rot_w[16];
				n   = rot_w[15];
				z   = (rot_w[15:0] == 16'd0);
			end
			rlx_pkg::SZ_LONG: begin
				res = rot_l[31:0];
				xo  = rot_l[32];
				n   = rot_l[31];
				z   = (rot_l[31:0] == 32'd0);
			end
			default: begin
				res = {16'd0, rot_w[15:0]};
				xo  = rot_w[16];
				n   = rot_w[15];
				z   = (rot_w[15:0] == 16'd0);
			end
		endcase
	end

	assign in_ready = !valid_q || m_tready;
	assign take     = in_valid && in_ready;

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
			xo_q  <= xo;
			n_q   <= n;
			z_q   <= z;
			cyc_q <= in_data.cycles;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {3'd0, cyc_q, 1'b0, z_q, n_q, xo_q, xo_q, res_q};

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking bench for the rotate-left-through-extend unit: directed and random ROXL traffic.
`timescale 1ns / 100ps
module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	// Receiver stall patterns
	typedef enum int {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_EVERY_THIRD
	} rx_mode_t;

	// Outcome of one ROXL instruction
	typedef struct packed {
		logic [31:0] value;
		logic        x;
		logic        c;
		logic        n;
		logic        z;
		logic        v;
		logic [7:0]  cycles;
	} roxl_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;      // opcode, operand, count_reg, x_in, pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;           // result, x, c, n, z, v, cycles, pad

	roxl_out_t   pending_results[$];
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int          burst_left = 0;
	rx_mode_t    rx_mode = RX_OPEN;
	int          hold_requests = 0;
	int          holds_served = 0;
	int          hold_left = 0;
	int unsigned rx_phase = 0;

	rotate_left_through_extend u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Rotate the sized operand left through the X ring and merge the untouched upper bits (cleared for the memory form)
	function automatic roxl_out_t predict_roxl(input logic [15:0] op, input logic [31:0] d,
			input logic [5:0] creg, input logic xin);
		roxl_out_t       r;
		rlx_pkg::size_t  sz;
		int unsigned     width, nbits, count, k;
		logic [63:0]     ring, valmask, ringmask;
		logic [31:0]     upper;
		logic [7:0]      cyc;
		sz = rlx_pkg::size_t'(op[7:6]);
		if (sz == rlx_pkg::SZ_MEM) begin
			// memory word, always one step
			width = rlx_pkg::RING_WORD;
			count = 1;
			cyc = rlx_pkg::CYC_MEM;
			upper = '0;
		end else begin
			if (op[5])
				count = creg;
			else
				count = (op[11:9] == 3'd0) ? rlx_pkg::IMM_ZERO_COUNT : op[11:9];
			cyc = rlx_pkg::CYC_BASE + 8'(2 * count);
			case (sz)
				rlx_pkg::SZ_BYTE: begin
					width = rlx_pkg::RING_BYTE;
					upper = d & 32'hffff_ff00;
				end
				rlx_pkg::SZ_WORD: begin
					width = rlx_pkg::RING_WORD;
					upper = d & 32'hffff_0000;
				end
				default: begin
					width = rlx_pkg::RING_LONG;
					upper = '0;
					cyc = cyc + rlx_pkg::CYC_LONG_EXTRA;
				end
			endcase
		end
		nbits = width - 1;
		valmask = (64'd1 << nbits) - 64'd1;
		ringmask = (64'd1 << width) - 64'd1;
		ring = (64'(xin) << nbits) | (64'(d) & valmask);
		k = count % width;
		if (k != 0)
			ring = ((ring << k) | (ring >> (width - k))) & ringmask;
		r.x = ring[nbits];
		r.c = ring[nbits];
		r.n = ring[nbits - 1];
		r.z = ((ring & valmask) == 64'd0);
		r.v = 1'b0;
		r.value = upper | 32'(ring & valmask);
		r.cycles = cyc;
		return r;
	endfunction

	// Instruction word: line E, count/register, left, size, i/r, ROXL type
	function automatic logic [15:0] roxl_op(input rlx_pkg::size_t sz, input logic by_reg,
			input logic [2:0] cnt);
		return {4'hE, cnt, 1'b1, sz, by_reg, 2'b10, 3'b000};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp);
		errors++;
		$display("tb: mismatch on %s: got %h, expected %h at %0t", what, got, exp, $realtime);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] exp);
		if (got !== exp)
			report_mismatch(what, got, exp);
	endtask

	// Record accepted instructions and check returned transactions in order
	always @(posedge clk) begin : result_check
		roxl_out_t exp;
		if (arst_n && s_tvalid && s_tready)
			pending_results.push_back(predict_roxl(s_tdata[15:0], s_tdata[47:16],
				s_tdata[53:48], s_tdata[54]));
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata[31:0], '0);
			end else begin
				exp = pending_results.pop_front();
				check_field("result", m_tdata[31:0], exp.value);
				check_field("x_out", m_tdata[32], exp.x);
				check_field("c_out", m_tdata[33], exp.c);
				check_field("n_out", m_tdata[34], exp.n);
				check_field("z_out", m_tdata[35], exp.z);
				check_field("v_out", m_tdata[36], exp.v);
				check_field("cycles", m_tdata[44:37], exp.cycles);
			end
		end
	end

	// Receiver: long hold on request, otherwise the current stall pattern
	always @(negedge clk) begin
		rx_phase <= rx_phase + 1;
		if (holds_served != hold_requests) begin
			holds_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:  m_tready <= 1'b1;
				RX_LIGHT: m_tready <= ($urandom_range(0, 99) < 75);
				RX_HEAVY: m_tready <= ($urandom_range(0, 99) < 25);
				default:  m_tready <= (rx_phase % 3 == 0);
			endcase
		end
	end

	// Offer one instruction; returns at the edge where it is taken, tvalid still high
	task automatic issue_roxl(input logic [15:0] op, input logic [31:0] d,
			input logic [5:0] creg, input logic xin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk) s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, xin, creg, d, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering and wait until every pending result has come back
	task automatic wait_drain;
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	function automatic logic [31:0] pick_operand;
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'd1 << $urandom_range(0, 31);
			3: return ~(32'd1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	task automatic issue_random(input int n);
		for (int i = 0; i < n; i++)
			issue_roxl(16'($urandom_range(0, 65535)), pick_operand(),
				6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
	endtask

	// Field extremes, each form and size, zero and ring-multiple counts
	task automatic test_directed;
		rx_mode = RX_OPEN;
		issue_roxl(roxl_op(rlx_pkg::SZ_BYTE, 1'b0, 3'd0), 32'ha5a5_a5a5, 6'd0, 1'b1);
		issue_roxl(roxl_op(rlx_pkg::SZ_BYTE, 1'b0, 3'd1), 32'hffff_ff80, 6'd63, 1'b0);
		issue_roxl(roxl_op(rlx_pkg::SZ_BYTE, 1'b0, 3'd7), 32'h1234_5601, 6'd0, 1'b1);
		issue_roxl(roxl_op(rlx_pkg::SZ_BYTE, 1'b0, 3'd4), 32'h0000_0000, 6'd0, 1'b0);
		issue_roxl(roxl_op(rlx_pkg::SZ_WORD, 1'b0, 3'd0), 32'h0000_ffff, 6'd0, 1'b0);
		issue_roxl(roxl_op(rlx_pkg::SZ_WORD, 1'b0, 3'd3), 32'hdead_8001, 6'd0, 1'b1);
		issue_roxl(roxl_op(rlx_pkg::SZ_LONG, 1'b0, 3'd1), 32'h8000_0000, 6'd0, 1'b0);
		issue_roxl(roxl_op(rlx_pkg::SZ_LONG, 1'b0, 3'd0), 32'hffff_ffff, 6'd0, 1'b1);
		// zero count: value kept, C takes X
		issue_roxl(roxl_op(rlx_pkg::SZ_BYTE, 1'b1, 3'd7), 32'h0000_0055, 6'd0, 1'b1);
		issue_roxl(roxl_op(rlx_pkg::SZ_LONG, 1'b1, 3'd0), 32'h0000_0000, 6'd0, 1'b0);
		// counts that are whole multiples of the ring
		issue_roxl(roxl_op(rlx_pkg::SZ_BYTE, 1'b1, 3'd0), 32'h0000_0081, 6'd9, 1'b0);
		issue_roxl(roxl_op(rlx_pkg::SZ_BYTE, 1'b1, 3'd2), 32'hffff_ff7e, 6'd18, 1'b1);
		issue_roxl(roxl_op(rlx_pkg::SZ_WORD, 1'b1, 3'd0), 32'h0000_8000, 6'd17, 1'b1);
		issue_roxl(roxl_op(rlx_pkg::SZ_WORD, 1'b1, 3'd5), 32'h5555_aaaa, 6'd34, 1'b0);
		issue_roxl(roxl_op(rlx_pkg::SZ_LONG, 1'b1, 3'd0), 32'h7fff_ffff, 6'd33, 1'b1);
		// largest register counts
		issue_roxl(roxl_op(rlx_pkg::SZ_LONG, 1'b1, 3'd0), 32'h0000_0001, 6'd63, 1'b0);
		issue_roxl(roxl_op(rlx_pkg::SZ_LONG, 1'b1, 3'd0), 32'hffff_ffff, 6'd32, 1'b0);
		issue_roxl(roxl_op(rlx_pkg::SZ_WORD, 1'b1, 3'd0), 32'hffff_0000, 6'd63, 1'b1);
		// memory form: one step, upper half cleared, count fields ignored
		issue_roxl(roxl_op(rlx_pkg::SZ_MEM, 1'b0, 3'd2), 32'hffff_8000, 6'd0, 1'b0);
		issue_roxl(roxl_op(rlx_pkg::SZ_MEM, 1'b0, 3'd2), 32'h0000_0000, 6'd63, 1'b1);
		issue_roxl(roxl_op(rlx_pkg::SZ_MEM, 1'b1, 3'd7), 32'h1234_7fff, 6'd40, 1'b1);
		// unrelated opcode bits are not decoded
		issue_roxl(16'h0000, 32'h0000_00ff, 6'd0, 1'b0);
		issue_roxl(16'hffff, 32'hffff_ffff, 6'd63, 1'b1);
		wait_drain();
	endtask

	// Random instructions under each receiver pattern
	task automatic test_receiver_patterns;
		rx_mode = RX_OPEN;
		issue_random(320);
		rx_mode = RX_LIGHT;
		issue_random(320);
		rx_mode = RX_HEAVY;
		issue_random(320);
		rx_mode = RX_EVERY_THIRD;
		issue_random(320);
		wait_drain();
	endtask

	// Receiver holds off while the sender keeps pushing, so the input stalls
	task automatic test_long_hold;
		rx_mode = RX_OPEN;
		hold_requests++;
		issue_random(60);
		wait_drain();
	endtask

	// Short bursts, each drained before the next
	task automatic test_drain_pauses;
		rx_mode = RX_LIGHT;
		for (int i = 0; i < 10; i++) begin
			issue_random(12);
			wait_drain();
		end
	endtask

	task automatic test_random_tail;
		rx_mode = RX_LIGHT;
		issue_random(180);
		wait_drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		test_directed();
		test_receiver_patterns();
		test_long_hold();
		test_drain_pauses();
		test_random_tail();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", pending_results.size(), '0);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
src/rlx_pkg.sv
src/rlx_front.sv
src/rlx_queue.sv
src/rlx_back.sv
src/rotate_left_through_extend.sv
verif/testbench.sv
